// ===== hw/rtl/pne_pkg.sv =====
// Shared types and constants for the photometric normal estimator.
// Holds the input and result word layouts and the controller/datapath interface.
// No dependencies.
package pne_pkg;

  typedef struct packed {
    logic               command;
    logic [5:0]         image_index;
    logic signed [23:0] coef_x;
    logic signed [23:0] coef_y;
    logic signed [23:0] coef_z;
    logic [7:0]         intensity;
    logic               mask_bit;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [23:0] grad_p;
    logic signed [23:0] grad_q;
    logic [7:0]         code_p;
    logic [7:0]         code_q;
    logic               written;
  } out_word_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Divider jobs, in the order they run
  localparam logic [2:0] OP_NX = 3'd0;
  localparam logic [2:0] OP_NY = 3'd1;
  localparam logic [2:0] OP_NZ = 3'd2;
  localparam logic [2:0] OP_GP = 3'd3;
  localparam logic [2:0] OP_GQ = 3'd4;

  localparam int CNT_W      = 6;
  localparam int SQ_LAST    = 3;
  localparam int SQRT_LAST  = 31;
  localparam int DIV_W      = 48;
  localparam int DIV_LAST   = DIV_W - 1;

  typedef struct packed {
    logic             accept;
    logic             mac;
    logic             capt;
    logic             shift;
    logic             sq_step;
    logic             sqrt_step;
    logic             div_start;
    logic             div_step;
    logic             div_store;
    logic             code_calc;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
    logic [2:0]       op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_hold;
    logic need_shift;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/pne_ctrl.sv =====
// Sequencer for the photometric normal estimator.
// Steps one word through accumulate, normalise, square root and divide jobs.
// Depends on pne_pkg.
module pne_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_stall,
  input  pne_pkg::ctrl_sts_t  sts,
  output pne_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAC    = 4'd1;
  localparam logic [3:0] S_CAPT   = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_DSET   = 4'd6;
  localparam logic [3:0] S_DRUN   = 4'd7;
  localparam logic [3:0] S_DSTORE = 4'd8;
  localparam logic [3:0] S_CODE   = 4'd9;
  localparam logic [3:0] S_OUTW   = 4'd10;

  logic [3:0]               state, state_next;
  logic [pne_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [2:0]               op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      op    <= pne_pkg::OP_NX;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      op    <= op_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.op     = op;
    state_next = state;
    cnt_next   = cnt;
    op_next    = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == pne_pkg::CMD_SAMPLE) state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac    = 1'b1;
        state_next = sts.last_hold ? S_CAPT : S_IDLE;
      end
      S_CAPT: begin
        cmd.capt   = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.need_shift) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = S_SQ;
          cnt_next   = '0;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt == pne_pkg::CNT_W'(pne_pkg::SQ_LAST)) begin
          state_next = S_SQRT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == pne_pkg::CNT_W'(pne_pkg::SQRT_LAST)) begin
          state_next = S_DSET;
          cnt_next   = '0;
          op_next    = pne_pkg::OP_NX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DSET: begin
        cmd.div_start = 1'b1;
        state_next    = S_DRUN;
        cnt_next      = '0;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        if (cnt == pne_pkg::CNT_W'(pne_pkg::DIV_LAST)) state_next = S_DSTORE;
        else cnt_next = cnt + 1'b1;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (op == pne_pkg::OP_GQ) begin
          state_next = S_CODE;
        end else begin
          op_next    = op + 1'b1;
          state_next = S_DSET;
        end
      end
      S_CODE: begin
        cmd.code_calc = 1'b1;
        state_next    = S_OUTW;
      end
      S_OUTW: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/pne_dp.sv =====
// Datapath for the photometric normal estimator: coefficient memory,
// accumulators, square root, shared divider and the output register.
// Depends on pne_pkg.
module pne_dp #(
  parameter int NUM_IMAGES = 23
) (
  input  logic                clk,
  input  logic                rst,
  input  pne_pkg::in_word_t   in_data,
  input  pne_pkg::ctrl_cmd_t  cmd,
  output pne_pkg::ctrl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output pne_pkg::out_word_t  out_data
);

  localparam int IW = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;

  // coefficient memory, x/y/z packed in one row
  logic [71:0] coef_mem [NUM_IMAGES];
  logic [71:0] rd_q;
  logic [IW-1:0] addr;
  logic in_range;

  assign addr     = in_data.image_index[IW-1:0];
  assign in_range = ({1'b0, in_data.image_index} < 7'(NUM_IMAGES));

  always_ff @(posedge clk) begin
    if (cmd.accept && in_range && in_data.command == pne_pkg::CMD_LOAD)
      coef_mem[addr] <= {in_data.coef_x, in_data.coef_y, in_data.coef_z};
    if (cmd.accept)
      rd_q <= coef_mem[addr];
  end

  // sample captured on accept
  logic [7:0] it_r;
  logic       range_r, last_r, mask_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_r    <= in_data.intensity;
      range_r <= in_range;
      last_r  <= in_data.last;
      mask_r  <= in_data.mask_bit;
    end
  end

  // multiply-accumulate
  logic signed [23:0] cx, cy, cz;
  logic signed [32:0] px, py, pz;
  logic [39:0] acc_x, acc_y, acc_z;

  assign cx = rd_q[71:48];
  assign cy = rd_q[47:24];
  assign cz = rd_q[23:0];
  assign px = $signed({1'b0, it_r}) * cx;
  assign py = $signed({1'b0, it_r}) * cy;
  assign pz = $signed({1'b0, it_r}) * cz;

  // magnitudes and signs of the captured vector
  logic [39:0] mag [3];
  logic        neg [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (cmd.mac && range_r) begin
      acc_x <= acc_x + {{7{px[32]}}, px};
      acc_y <= acc_y + {{7{py[32]}}, py};
      acc_z <= acc_z + {{7{pz[32]}}, pz};
    end else if (cmd.capt) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capt) begin
      neg[0] <= acc_x[39];
      neg[1] <= acc_y[39];
      neg[2] <= acc_z[39];
      mag[0] <= acc_x[39] ? 40'd0 - acc_x : acc_x;
      mag[1] <= acc_y[39] ? 40'd0 - acc_y : acc_y;
      mag[2] <= acc_z[39] ? 40'd0 - acc_z : acc_z;
    end else if (cmd.shift) begin
      mag[0] <= mag[0] >> 1;
      mag[1] <= mag[1] >> 1;
      mag[2] <= mag[2] >> 1;
    end
  end

  // sum of squares through one shared multiplier, then bitwise square root
  logic [29:0] mag_sel;
  logic [59:0] sq_prod;
  logic [63:0] sum, res, bitv, trial;
  logic [5:0]  bit_pos;

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    mag_sel = mag[0][29:0];
      2'd1:    mag_sel = mag[1][29:0];
      2'd2:    mag_sel = mag[2][29:0];
      default: mag_sel = '0;
    endcase
  end

  assign bit_pos = 6'd62 - {cmd.cnt[4:0], 1'b0};
  assign bitv    = 64'd1 << bit_pos;
  assign trial   = res + bitv;

  always_ff @(posedge clk) begin
    if (cmd.sq_step) begin
      sq_prod <= mag_sel * mag_sel;
      if (cmd.cnt == '0) sum <= '0;
      else sum <= sum + {4'd0, sq_prod};
    end else if (cmd.sqrt_step) begin
      if (sum >= trial) begin
        sum <= sum - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
    if (cmd.capt) res <= '0;
  end

  // shared restoring divider, one quotient bit a cycle
  logic [31:0] r;
  logic signed [15:0] nrm [3];
  logic [15:0] an, az;
  logic [pne_pkg::DIV_W-1:0] num, quo, num_init;
  logic [31:0] den, den_init, rem;
  logic [32:0] dtrial;
  logic [29:0] mag_div;

  assign r = res[31:0];

  always_comb begin
    case (cmd.op)
      pne_pkg::OP_NX: mag_div = mag[0][29:0];
      pne_pkg::OP_NY: mag_div = mag[1][29:0];
      default:        mag_div = mag[2][29:0];
    endcase
  end

  always_comb begin
    an = 16'd0;
    case (cmd.op)
      pne_pkg::OP_GP: an = nrm[0][15] ? 16'd0 - nrm[0] : nrm[0];
      pne_pkg::OP_GQ: an = nrm[1][15] ? 16'd0 - nrm[1] : nrm[1];
      default:        an = 16'd0;
    endcase
    az = nrm[2][15] ? 16'd0 - nrm[2] : nrm[2];
    case (cmd.op)
      pne_pkg::OP_NX, pne_pkg::OP_NY, pne_pkg::OP_NZ: begin
        num_init = {3'd0, mag_div, 15'd0} + {17'd0, r[31:1]};
        den_init = r;
      end
      default: begin
        num_init = {16'd0, an, 16'd0} + {33'd0, az[15:1]};
        den_init = {16'd0, az};
      end
    endcase
  end

  assign dtrial = {rem, num[pne_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num <= num_init;
      den <= den_init;
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      num <= num << 1;
      if (dtrial >= {1'b0, den}) begin
        rem <= 32'(dtrial - {1'b0, den});
        quo <= {quo[pne_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= dtrial[31:0];
        quo <= {quo[pne_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  // saturate and sign the quotient
  logic [14:0] uq;
  logic signed [15:0] uval;
  logic        gneg;
  logic signed [23:0] gval;
  logic signed [23:0] gp, gq;
  logic               uneg;
  logic               wr_next, wr_r;

  always_comb begin
    case (cmd.op)
      pne_pkg::OP_NX: uneg = neg[0];
      pne_pkg::OP_NY: uneg = neg[1];
      default:        uneg = neg[2];
    endcase
    uq   = (quo > 48'd32767) ? 15'h7FFF : quo[14:0];
    uval = uneg ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
    if (r == '0) uval = '0;
    gneg = ((cmd.op == pne_pkg::OP_GP) ? nrm[0][15] : nrm[1][15]) ^ nrm[2][15];
    if (gneg) gval = (quo > 48'd8388608) ? 24'sh800000 : -$signed(quo[23:0]);
    else gval = (quo > 48'd8388607) ? 24'sh7FFFFF : $signed(quo[23:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.op)
        pne_pkg::OP_NX: nrm[0] <= uval;
        pne_pkg::OP_NY: nrm[1] <= uval;
        // a zero z component stands for one
        pne_pkg::OP_NZ: nrm[2] <= (uval == '0) ? 16'sh7FFF : uval;
        pne_pkg::OP_GP: gp <= gval;
        default:        gq <= gval;
      endcase
    end else if (cmd.code_calc && !wr_next) begin
      gp <= '0;
      gq <= '0;
    end
  end

  // display codes
  logic signed [24:0] gp_off, gq_off;
  logic signed [32:0] tp, tq;

  assign wr_next = mask_r && (gp != '0 || gq != '0);
  assign gp_off  = (wr_next ? {gp[23], gp} : 25'sd0) + 25'sd65536;
  assign gq_off  = (wr_next ? {gq[23], gq} : 25'sd0) + 25'sd65536;

  always_ff @(posedge clk) begin
    if (cmd.code_calc) begin
      wr_r <= wr_next;
      tp   <= gp_off * 33'sd127;
      tq   <= gq_off * 33'sd127;
    end
  end

  function automatic logic [7:0] code_clamp(input logic signed [32:0] t);
    logic [16:0] hi;
    begin
      hi = t[32:16];
      if (t[32]) code_clamp = 8'd0;
      else if (hi > 17'd255) code_clamp = 8'd255;
      else code_clamp = hi[7:0];
    end
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.normal_x <= nrm[0];
      out_data.normal_y <= nrm[1];
      out_data.normal_z <= nrm[2];
      out_data.grad_p   <= gp;
      out_data.grad_q   <= gq;
      out_data.code_p   <= code_clamp(tp);
      out_data.code_q   <= code_clamp(tq);
      out_data.written  <= wr_r;
    end
  end

  assign sts.last_hold  = last_r;
  assign sts.need_shift = (mag[0][39:30] != '0) || (mag[1][39:30] != '0) ||
                          (mag[2][39:30] != '0);
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// ===== hw/rtl/photometric_normal_estimator_core.sv =====
// A load is written on acceptance; a sample also runs an accumulate step. A
// sample that ends a pixel then runs normalising shifts, 4 squares, 32 root
// steps, five divides and a code step before its word is loaded for output.
// Throughput: one word at a time; the next word is taken once the current
// one is done, while a finished result may still wait in the output register.
// Reset (rst, synchronous) clears accumulators and control; coefficients unset.
module photometric_normal_estimator_core #(
  parameter int NUM_IMAGES = 23
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pne_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pne_pkg::out_word_t out_data
);

  pne_pkg::ctrl_cmd_t cmd;
  pne_pkg::ctrl_sts_t sts;

  pne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pne_dp #(.NUM_IMAGES(NUM_IMAGES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/pne_checker.sv =====
// Port-level checks for the photometric normal estimator.
// Bound to photometric_normal_estimator_core; depends on pne_pkg.
module pne_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pne_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

  a_no_result_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared straight after an accepted word");

  a_unwritten: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.written |-> out_data.grad_p == 24'sd0 &&
      out_data.grad_q == 24'sd0 && out_data.code_p == 8'd127 &&
      out_data.code_q == 8'd127)
    else $error("unwritten result carries gradients");

  a_nz_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.normal_z != 16'sd0)
    else $error("normal z component is zero");

endmodule

bind photometric_normal_estimator_core pne_port_checker u_pne_checker (.*);
